// ----- rtl/asfd_pkg.sv -----
// Package: types, widths and codes shared by the shared-face detector.
`default_nettype none

package asfd_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int EPS_WIDTH   = 31;
	localparam int AXES        = 3;
	localparam int CMP_WIDTH   = ((COORD_WIDTH + 1 > EPS_WIDTH) ? COORD_WIDTH + 1 : EPS_WIDTH) + 1;

	localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(1);

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef enum logic [1:0] {
		CLS_DISJOINT = 2'd0,
		CLS_OVERLAP  = 2'd1,
		CLS_ALIGNED  = 2'd2
	} axis_cls_t;

	typedef struct packed {
		axis_cls_t cls;
		coord_t    pv;
		coord_t    lo;
		coord_t    hi;
	} axis_res_t;

	typedef struct packed {
		coord_t a_min_x;
		coord_t a_min_y;
		coord_t a_min_z;
		coord_t a_max_x;
		coord_t a_max_y;
		coord_t a_max_z;
		coord_t b_min_x;
		coord_t b_min_y;
		coord_t b_min_z;
		coord_t b_max_x;
		coord_t b_max_y;
		coord_t b_max_z;
	} box_word_t;

	typedef struct packed {
		logic       shared;
		logic [1:0] plane_axis;
		coord_t     plane_value;
		coord_t     area_min_x;
		coord_t     area_min_y;
		coord_t     area_min_z;
		coord_t     area_max_x;
		coord_t     area_max_y;
		coord_t     area_max_z;
	} face_word_t;

endpackage

`default_nettype wire

// ----- rtl/aabb_shared_face_detect.sv -----
// Top level: two-register pipeline around the shared-face test.
// Takes one box pair per cycle while the output is not stalled and returns one result word per
// pair; the word is valid on the output from the clock edge after the one that accepts the
// pair when the output is not stalled. The pair is held in an input register,
// the per-axis separations, epsilon compares and intersection selection sit in one
// combinational step, and the result lands in an output register; each register advances
// whenever the stage after it is empty or being drained, so a pair is accepted even while a
// finished result waits. The epsilon register resets to 1 and should only be written while
// no pair is in flight. A pair that does not share a face returns an all-zero result word.
`default_nettype none

module aabb_shared_face_detect
	import asfd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [EPS_WIDTH-1:0] cfg_wdata,
	input  wire logic                 box_valid,
	output logic                      box_ready,
	input  wire box_word_t            box,
	output logic                      face_valid,
	input  wire logic                 face_ready,
	output face_word_t                face
);

	logic [EPS_WIDTH-1:0] eps_q;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 adv_s2;
	box_word_t            box_s1;
	face_word_t           face_s2;
	face_word_t           face_c;
	coord_t               a_min [AXES];
	coord_t               a_max [AXES];
	coord_t               b_min [AXES];
	coord_t               b_max [AXES];
	axis_res_t            ax [AXES];

	assign adv_s2     = !valid_s2 || face_ready;
	assign box_ready  = !valid_s1 || adv_s2;
	assign face_valid = valid_s2;
	assign face       = face_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q    <= EPS_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				eps_q <= cfg_wdata;
			end
			if (box_ready) begin
				valid_s1 <= box_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (box_valid && box_ready) begin
			box_s1 <= box;
		end
		if (valid_s1 && adv_s2) begin
			face_s2 <= face_c;
		end
	end

	always_comb begin
		a_min[0] = box_s1.a_min_x;
		a_min[1] = box_s1.a_min_y;
		a_min[2] = box_s1.a_min_z;
		a_max[0] = box_s1.a_max_x;
		a_max[1] = box_s1.a_max_y;
		a_max[2] = box_s1.a_max_z;
		b_min[0] = box_s1.b_min_x;
		b_min[1] = box_s1.b_min_y;
		b_min[2] = box_s1.b_min_z;
		b_max[0] = box_s1.b_max_x;
		b_max[1] = box_s1.b_max_y;
		b_max[2] = box_s1.b_max_z;
	end

	for (genvar i = 0; i < AXES; i++) begin : g_axis
		asfd_axis u_axis (
			.a_min (a_min[i]),
			.a_max (a_max[i]),
			.b_min (b_min[i]),
			.b_max (b_max[i]),
			.eps   (eps_q),
			.res   (ax[i])
		);
	end

	asfd_select u_select (
		.ax   (ax),
		.face (face_c)
	);

endmodule

`default_nettype wire

// ----- rtl/asfd_axis.sv -----
// Per-axis separation class, contact plane value and interval overlap.
`default_nettype none

module asfd_axis
	import asfd_pkg::*;
(
	input  wire coord_t                 a_min,
	input  wire coord_t                 a_max,
	input  wire coord_t                 b_min,
	input  wire coord_t                 b_max,
	input  wire logic [EPS_WIDTH-1:0]   eps,
	output axis_res_t                   res
);

	logic                          a_low;
	coord_t                        hmin;
	coord_t                        lmax;
	logic signed [COORD_WIDTH:0]   sep;
	logic signed [CMP_WIDTH-1:0]   sep_w;
	logic signed [CMP_WIDTH-1:0]   eps_w;
	logic signed [CMP_WIDTH-1:0]   neg_eps_w;

	// equal mins: second box is the lower one
	assign a_low     = a_min < b_min;
	assign hmin      = a_low ? b_min : a_min;
	assign lmax      = a_low ? a_max : b_max;
	assign sep       = (COORD_WIDTH + 1)'(hmin) - (COORD_WIDTH + 1)'(lmax);
	assign sep_w     = CMP_WIDTH'(sep);
	assign eps_w     = signed'(CMP_WIDTH'(eps));
	assign neg_eps_w = -eps_w;

	always_comb begin
		if (sep_w > eps_w) begin
			res.cls = CLS_DISJOINT;
		end else if (sep_w < neg_eps_w) begin
			res.cls = CLS_OVERLAP;
		end else begin
			res.cls = CLS_ALIGNED;
		end
		res.pv = lmax;
		res.lo = hmin;
		res.hi = (a_max < b_max) ? a_max : b_max;
	end

endmodule

`default_nettype wire

// ----- rtl/asfd_select.sv -----
// Combines the three axis results into the shared-face result word.
`default_nettype none

module asfd_select
	import asfd_pkg::*;
(
	input  wire axis_res_t ax [AXES],
	output face_word_t     face
);

	logic [AXES-1:0] aligned;
	logic [AXES-1:0] disjoint;
	logic            shared;
	logic [1:0]      axis;
	coord_t          pv;
	coord_t          lo [AXES];
	coord_t          hi [AXES];

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			aligned[i]  = (ax[i].cls == CLS_ALIGNED);
			disjoint[i] = (ax[i].cls == CLS_DISJOINT);
		end
		shared = (disjoint == '0) && $onehot(aligned);

		axis = AXIS_X;
		pv   = ax[0].pv;
		if (aligned[1]) begin
			axis = AXIS_Y;
			pv   = ax[1].pv;
		end
		if (aligned[2]) begin
			axis = AXIS_Z;
			pv   = ax[2].pv;
		end

		for (int i = 0; i < AXES; i++) begin
			lo[i] = aligned[i] ? pv : ax[i].lo;
			hi[i] = aligned[i] ? pv : ax[i].hi;
		end

		face = '0;
		if (shared) begin
			face.shared      = 1'b1;
			face.plane_axis  = axis;
			face.plane_value = pv;
			face.area_min_x  = lo[0];
			face.area_min_y  = lo[1];
			face.area_min_z  = lo[2];
			face.area_max_x  = hi[0];
			face.area_max_y  = hi[1];
			face.area_max_z  = hi[2];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/asfd_checker.sv -----
// Port-level checker for the shared-face detector, bound to the top level.
`default_nettype none

module asfd_checker
	import asfd_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       box_ready,
	input wire logic       face_valid,
	input wire logic       face_ready,
	input wire face_word_t face
);

	// not shared: whole word is zero
	a_zero_when_not_shared: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid && !face.shared |->
			face.plane_axis == '0 && face.plane_value == '0 &&
			face.area_min_x == '0 && face.area_min_y == '0 && face.area_min_z == '0 &&
			face.area_max_x == '0 && face.area_max_y == '0 && face.area_max_z == '0)
		else $error("non-shared word not zero");

	a_axis_code: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid && face.shared |->
			face.plane_axis == AXIS_X || face.plane_axis == AXIS_Y ||
			face.plane_axis == AXIS_Z)
		else $error("bad plane axis");

	// flat rectangle on the plane axis
	a_flat_on_plane: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid && face.shared |->
			(face.plane_axis != AXIS_X ||
				(face.area_min_x == face.plane_value && face.area_max_x == face.plane_value)) &&
			(face.plane_axis != AXIS_Y ||
				(face.area_min_y == face.plane_value && face.area_max_y == face.plane_value)) &&
			(face.plane_axis != AXIS_Z ||
				(face.area_min_z == face.plane_value && face.area_max_z == face.plane_value)))
		else $error("rectangle not flat on plane axis");

	// draining the output always frees the input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		face_ready |-> box_ready)
		else $error("input blocked while output drains");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid && !face_ready |=> face_valid && $stable(face))
		else $error("stalled word changed");

endmodule

bind aabb_shared_face_detect asfd_checker u_chk (.*);

`default_nettype wire
